// ----- sv/wsd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants for the waypoint sequencer
// Waypoint record, input and result items, configuration set, opcodes and
// register indexes, plus the 16-bit saturation helper.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int MAX_WAYPOINTS = 8;
    localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    typedef logic signed [15:0] t_coord;
    typedef logic [IDX_W-1:0]   t_idx;

    typedef enum logic {
        OP_MEASURE = 1'b0,
        OP_WRITE   = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATH_LENGTH       = 3'd0,
        CFG_DIST_THRESHOLD    = 3'd1,
        CFG_SHORT_DWELL       = 3'd2,
        CFG_LONG_DWELL        = 3'd3,
        CFG_HEADING_TOLERANCE = 3'd4,
        CFG_SNAP_BAND         = 3'd5,
        CFG_SLEW_STEP         = 3'd6
    } t_cfg_index;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord h;
    } t_waypoint;

    typedef struct packed {
        logic [3:0]  path_length;
        logic [15:0] dist_threshold;
        logic [15:0] short_dwell;
        logic [15:0] long_dwell;
        logic [11:0] heading_tolerance;
        logic [11:0] snap_band;
        logic [7:0]  slew_step;
    } t_cfg;

    localparam logic [3:0]  RST_PATH_LENGTH       = 4'd6;
    localparam logic [15:0] RST_DIST_THRESHOLD    = 16'd50;
    localparam logic [15:0] RST_SHORT_DWELL       = 16'd40;
    localparam logic [15:0] RST_LONG_DWELL        = 16'd200;
    localparam logic [11:0] RST_HEADING_TOLERANCE = 12'd50;
    localparam logic [11:0] RST_SNAP_BAND         = 12'd30;
    localparam logic [7:0]  RST_SLEW_STEP         = 8'd2;

    typedef struct packed {
        t_opcode   opcode;
        t_coord    x_pos;
        t_coord    y_pos;
        t_coord    heading;
        t_idx      entry_index;
        t_waypoint entry;
    } t_item;

    typedef struct packed {
        t_coord x_target;
        t_coord y_target;
        t_coord heading_target;
        t_idx   waypoint_index;
        logic   advanced;
    } t_result;

    // clamp a 17-bit signed value into the 16-bit signed range
    function automatic t_coord sat16(input logic signed [16:0] v);
        t_coord r;
        if (v > 17'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -17'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/wsd_cfg.sv -----
// ----------------------------------------------------------------------------
// wsd_cfg: configuration register file
// Seven write-only registers, loaded through a plain indexed write port.
// ----------------------------------------------------------------------------
module wsd_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [wsd_pkg::CFG_IDX_W-1:0]       i_index,
    input  logic [wsd_pkg::CFG_DATA_W-1:0]      i_data,
    output wsd_pkg::t_cfg                       o_cfg
);
    import wsd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.path_length       <= RST_PATH_LENGTH;
            r_cfg.dist_threshold    <= RST_DIST_THRESHOLD;
            r_cfg.short_dwell       <= RST_SHORT_DWELL;
            r_cfg.long_dwell        <= RST_LONG_DWELL;
            r_cfg.heading_tolerance <= RST_HEADING_TOLERANCE;
            r_cfg.snap_band         <= RST_SNAP_BAND;
            r_cfg.slew_step         <= RST_SLEW_STEP;
        end else if (i_wr_en) begin
            unique case (t_cfg_index'(i_index))
                CFG_PATH_LENGTH:       r_cfg.path_length       <= i_data[3:0];
                CFG_DIST_THRESHOLD:    r_cfg.dist_threshold    <= i_data;
                CFG_SHORT_DWELL:       r_cfg.short_dwell       <= i_data;
                CFG_LONG_DWELL:        r_cfg.long_dwell        <= i_data;
                CFG_HEADING_TOLERANCE: r_cfg.heading_tolerance <= i_data[11:0];
                CFG_SNAP_BAND:         r_cfg.snap_band         <= i_data[11:0];
                CFG_SLEW_STEP:         r_cfg.slew_step         <= i_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/wsd_step.sv -----
// ----------------------------------------------------------------------------
// wsd_step: input register, sequencer state and single-pass step logic
// Holds the waypoint table, cached current and previous entries, index,
// dwell count and held heading; one item is resolved per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module wsd_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  wsd_pkg::t_item     i_item,
    output logic               o_stall,
    input  wsd_pkg::t_cfg      i_cfg,
    input  logic               i_ready,
    output logic               o_res_valid,
    output wsd_pkg::t_result   o_res
);
    import wsd_pkg::*;

    // input stage
    logic      r_in_valid;
    t_item     r_item;

    // sequencer state
    t_waypoint r_table [MAX_WAYPOINTS];
    t_waypoint r_cur;    // copy of r_table[r_idx]
    t_waypoint r_prev;   // copy of r_table[r_idx - 1]
    t_idx      r_idx;
    logic [15:0] r_dwell;
    t_coord    r_held;

    t_waypoint n_cur, n_prev;
    t_idx      n_idx;
    logic [15:0] n_dwell;
    t_coord    n_held;
    logic      adv;

    logic                fire;
    logic                accept;
    t_waypoint           rd_next;
    logic signed [16:0]  head_err;
    logic [16:0]         head_abs;
    logic                in_tol;
    logic                repeat_wp;
    logic signed [16:0]  dx_s, dy_s;
    logic [16:0]         dx, dy, dmax;
    logic                near;
    logic [15:0]         cnt1;
    logic [15:0]         limit;
    logic                hit;
    logic [IDX_W:0]      nxt_w;
    t_idx                nxt_idx;
    logic signed [16:0]  held_w, diff, snap_s, step_s;

    assign fire    = r_in_valid & i_ready;
    assign o_stall = r_in_valid & ~i_ready;
    assign accept  = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        // next index with wrap at path length
        nxt_w   = {1'b0, r_idx} + 1'b1;
        nxt_idx = (nxt_w >= (IDX_W+1)'(i_cfg.path_length) || nxt_w[IDX_W])
                  ? '0 : nxt_w[IDX_W-1:0];
        rd_next = r_table[nxt_idx];

        head_err = {r_item.heading[15], r_item.heading} - {r_cur.h[15], r_cur.h};
        head_abs = head_err[16] ? 17'(-head_err) : 17'(head_err);
        in_tol   = head_abs < {5'b0, i_cfg.heading_tolerance};

        repeat_wp = (r_idx > t_idx'(1)) && (r_cur == r_prev);

        dx_s = {r_item.x_pos[15], r_item.x_pos} - {r_cur.x[15], r_cur.x};
        dy_s = {r_item.y_pos[15], r_item.y_pos} - {r_cur.y[15], r_cur.y};
        dx   = dx_s[16] ? 17'(-dx_s) : 17'(dx_s);
        dy   = dy_s[16] ? 17'(-dy_s) : 17'(dy_s);
        dmax = (dx > dy) ? dx : dy;
        near = dmax < {1'b0, i_cfg.dist_threshold};

        cnt1  = r_dwell + 16'd1;
        limit = repeat_wp ? i_cfg.long_dwell : i_cfg.short_dwell;
        hit   = (cnt1 == limit);

        held_w = {r_held[15], r_held};
        diff   = held_w - {r_cur.h[15], r_cur.h};
        snap_s = $signed({5'b0, i_cfg.snap_band});
        step_s = $signed({9'b0, i_cfg.slew_step});

        n_cur   = r_cur;
        n_prev  = r_prev;
        n_idx   = r_idx;
        n_dwell = r_dwell;
        n_held  = r_held;
        adv     = 1'b0;

        if (r_item.opcode == OP_WRITE) begin
            if (r_item.entry_index == r_idx) begin
                n_cur = r_item.entry;
            end
            if (r_item.entry_index == t_idx'(r_idx - 1'b1)) begin
                n_prev = r_item.entry;
            end
        end else if (in_tol) begin
            if (repeat_wp || near) begin
                adv     = hit;
                n_dwell = hit ? 16'd0 : cnt1;
            end else begin
                n_dwell = 16'd0;
            end
            if (adv) begin
                n_idx  = nxt_idx;
                n_cur  = rd_next;
                // after a wrap to slot 0 the previous copy is never consulted
                n_prev = r_cur;
            end
        end else begin
            if (diff > snap_s) begin
                n_held = sat16(held_w - step_s);
            end else if (diff < -snap_s) begin
                n_held = sat16(held_w + step_s);
            end else begin
                n_held = r_cur.h;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_dwell <= '0;
            r_held  <= '0;
        end else if (fire) begin
            r_idx   <= n_idx;
            r_dwell <= n_dwell;
            r_held  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_cur  <= n_cur;
            r_prev <= n_prev;
            if (r_item.opcode == OP_WRITE) begin
                r_table[r_item.entry_index] <= r_item.entry;
            end
        end
    end

    assign o_res_valid          = fire;
    assign o_res.x_target       = n_cur.x;
    assign o_res.y_target       = n_cur.y;
    assign o_res.heading_target = n_held;
    assign o_res.waypoint_index = n_idx;
    assign o_res.advanced       = adv;

`ifndef SYNTHESIS
    a_dwell_clear_on_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && adv |=> r_dwell == 16'd0)
        else $error("dwell count not cleared after advance");

    a_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !adv |=> r_idx == $past(r_idx))
        else $error("index moved without advance");

    a_dwell_hold_off_tol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_item.opcode == OP_MEASURE && !in_tol |=> $stable(r_dwell))
        else $error("dwell count changed while heading off tolerance");
`endif

endmodule

// ----- sv/wsd_skid.sv -----
// ----------------------------------------------------------------------------
// wsd_skid: output register with skid stage
// Parks one result while the receiver stalls so the step stage keeps going.
// ----------------------------------------------------------------------------
module wsd_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_valid,
    input  wsd_pkg::t_result   i_res,
    output logic               o_ready,
    output logic               o_valid,
    output wsd_pkg::t_result   o_res,
    input  logic               i_stall
);
    import wsd_pkg::*;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    n_out_valid, n_skid_valid;
    t_result n_out, n_skid;
    logic    take, free;

    always_comb begin
        take         = r_out_valid & ~i_stall;
        free         = ~r_out_valid | take;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = i_res_valid;
                if (i_res_valid) begin
                    n_out = i_res;
                end
            end
        end else if (i_res_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_ready = ~r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !r_skid_valid)
        else $error("result offered while skid stage full");
`endif

endmodule

// ----- sv/waypoint_sequencer_with_dwell.sv -----
// ----------------------------------------------------------------------------
// waypoint_sequencer_with_dwell: waypoint guidance sequencer top level
// Loads waypoints, slews the heading setpoint and advances through the path
// after a dwell on position or on a repeated waypoint.
// ----------------------------------------------------------------------------
// Usage
//  - Input channel (i_in_valid / o_in_stall): opcode OP_WRITE stores a
//    waypoint in slot i_entry_index; OP_MEASURE carries position and heading.
//  - Every input transfer yields exactly one result transfer on the output
//    channel (o_out_valid / i_out_stall), in order.
//  - An item passes the input register, then the result register, before
//    its result can transfer; o_out_valid rises with the result register.
//    Throughput: one item per cycle while the output buffer has room, set by the
//    single step stage that updates index, dwell count and held heading.
//  - Receiver stall: a two-deep output buffer (result register plus skid)
//    absorbs one further result; only when both are full does o_in_stall
//    rise. Nothing is dropped or repeated.
//  - Reset (i_rst_n low, synchronous): index, dwell count and held heading go
//    to zero, registers to their defaults, channels empty. Table contents are
//    not cleared; slots must be written before they are used.
//  - Configuration writes (i_cfg_wr_en) take effect at once and belong to
//    idle periods only.
// ----------------------------------------------------------------------------
module waypoint_sequencer_with_dwell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_wr_en,
    input  logic [wsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wsd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_opcode,
    input  logic signed [15:0]               i_x_pos,
    input  logic signed [15:0]               i_y_pos,
    input  logic signed [15:0]               i_heading,
    input  logic [2:0]                       i_entry_index,
    input  logic signed [15:0]               i_entry_x,
    input  logic signed [15:0]               i_entry_y,
    input  logic signed [15:0]               i_entry_heading,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [15:0]               o_x_target,
    output logic signed [15:0]               o_y_target,
    output logic signed [15:0]               o_heading_target,
    output logic [2:0]                       o_waypoint_index,
    output logic                             o_advanced
);
    import wsd_pkg::*;

    t_cfg    cfg;
    t_item   item;
    t_result step_res, out_res;
    logic    step_valid, buf_ready;

    // pack the item fields
    assign item.opcode      = t_opcode'(i_opcode);
    assign item.x_pos       = i_x_pos;
    assign item.y_pos       = i_y_pos;
    assign item.heading     = i_heading;
    assign item.entry_index = i_entry_index;
    assign item.entry.x     = i_entry_x;
    assign item.entry.y     = i_entry_y;
    assign item.entry.h     = i_entry_heading;

    wsd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // step stage: stalls only when the output buffer is full
    wsd_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_item      (item),
        .o_stall     (o_in_stall),
        .i_cfg       (cfg),
        .i_ready     (buf_ready),
        .o_res_valid (step_valid),
        .o_res       (step_res)
    );

    wsd_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (step_valid),
        .i_res       (step_res),
        .o_ready     (buf_ready),
        .o_valid     (o_out_valid),
        .o_res       (out_res),
        .i_stall     (i_out_stall)
    );

    assign o_x_target       = out_res.x_target;
    assign o_y_target       = out_res.y_target;
    assign o_heading_target = out_res.heading_target;
    assign o_waypoint_index = out_res.waypoint_index;
    assign o_advanced       = out_res.advanced;

endmodule

// ----- test/waypoint_sequencer_with_dwell_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_sequencer_with_dwell_tb: self-checking bench for the sequencer
// A table of directed transfers comes first, then randomised phases, each
// under its own register set. A behavioural model of the guidance step
// predicts every result. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module waypoint_sequencer_with_dwell_tb;
    import wsd_pkg::*;

    localparam int SETTLE_CYCLES = 4;    // result path is two deep, plus margin
    localparam int STALL_LIMIT   = 400;  // cycles without any transfer
    localparam int N_PHASES      = 6;

    typedef enum logic {
        ROW_CFG,
        ROW_ITEM
    } t_row_kind;

    // one line of the directed table: a register write or an input transfer
    typedef struct {
        t_row_kind   kind;
        t_cfg_index  reg_sel;
        logic [15:0] reg_val;
        t_item       item;
        bit          has_exp;
        t_result     exp_res;
    } t_dir_row;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_stall;
    logic                  i_opcode        = 1'b0;
    logic signed [15:0]    i_x_pos         = '0;
    logic signed [15:0]    i_y_pos         = '0;
    logic signed [15:0]    i_heading       = '0;
    logic [2:0]            i_entry_index   = '0;
    logic signed [15:0]    i_entry_x       = '0;
    logic signed [15:0]    i_entry_y       = '0;
    logic signed [15:0]    i_entry_heading = '0;
    logic                  o_out_valid;
    logic                  i_out_stall     = 1'b0;
    logic signed [15:0]    o_x_target;
    logic signed [15:0]    o_y_target;
    logic signed [15:0]    o_heading_target;
    logic [2:0]            o_waypoint_index;
    logic                  o_advanced;

    waypoint_sequencer_with_dwell u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_x_pos          (i_x_pos),
        .i_y_pos          (i_y_pos),
        .i_heading        (i_heading),
        .i_entry_index    (i_entry_index),
        .i_entry_x        (i_entry_x),
        .i_entry_y        (i_entry_y),
        .i_entry_heading  (i_entry_heading),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_x_target       (o_x_target),
        .o_y_target       (o_y_target),
        .o_heading_target (o_heading_target),
        .o_waypoint_index (o_waypoint_index),
        .o_advanced       (o_advanced)
    );

    // Guidance model: own copy of table, index, dwell count, heading setpoint
    // and registers. Updated at the edge where an input transfer completes.
    t_waypoint   wp_tab [MAX_WAYPOINTS];
    int unsigned cur_wp    = 0;
    int unsigned dwell_cnt = 0;
    int          held_hdg  = 0;
    t_cfg        cfg_m;

    t_result     guidance_q [$];   // predicted results, oldest first
    t_dir_row    dir_rows [$];
    int          err_count   = 0;
    int          idle_cycles = 0;
    bit          quiet       = 1'b0;  // both sides run flat out while set

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // model helpers
    // ------------------------------------------------------------------
    function automatic int clamp16(input int v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // 16-bit dwell counter; true on the count that matches the limit
    function automatic bit dwell_done(input int unsigned lim);
        dwell_cnt = (dwell_cnt + 1) & 32'hFFFF;
        if (dwell_cnt == lim) begin
            dwell_cnt = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // one guidance step: returns the result the block must give for item it
    function automatic t_result guide_step(input t_item it);
        t_result     res;
        t_waypoint   w;
        t_waypoint   p;
        int          ph;
        int          span;
        int          diff;
        int          tol;
        int          thr;
        int          snap;
        int          step;
        int unsigned nxt;
        bit          adv;
        bit          same_as_prev;
        adv  = 1'b0;
        tol  = cfg_m.heading_tolerance;
        thr  = cfg_m.dist_threshold;
        snap = cfg_m.snap_band;
        step = cfg_m.slew_step;
        if (it.opcode == OP_WRITE) begin
            wp_tab[it.entry_index] = it.entry;
        end else begin
            w  = wp_tab[cur_wp];
            ph = $signed(it.heading);
            if (mag(ph - $signed(w.h)) < tol) begin
                // heading settled: repeated waypoint holds, others need range
                p = wp_tab[(cur_wp + MAX_WAYPOINTS - 1) % MAX_WAYPOINTS];
                same_as_prev = (cur_wp > 1) && (w == p);
                if (same_as_prev) begin
                    adv = dwell_done(cfg_m.long_dwell);
                end else begin
                    span = mag($signed(it.x_pos) - $signed(w.x));
                    if (mag($signed(it.y_pos) - $signed(w.y)) > span) begin
                        span = mag($signed(it.y_pos) - $signed(w.y));
                    end
                    if (span < thr) begin
                        adv = dwell_done(cfg_m.short_dwell);
                    end else begin
                        dwell_cnt = 0;
                    end
                end
                if (adv) begin
                    nxt = cur_wp + 1;
                    if (nxt >= cfg_m.path_length || nxt >= MAX_WAYPOINTS) begin
                        nxt = 0;
                    end
                    cur_wp = nxt;
                end
            end else begin
                // heading off: slew the setpoint, dwell count untouched
                diff = held_hdg - $signed(w.h);
                if (diff > snap) begin
                    held_hdg = clamp16(held_hdg - step);
                end else if (diff < -snap) begin
                    held_hdg = clamp16(held_hdg + step);
                end else begin
                    held_hdg = $signed(w.h);
                end
            end
        end
        res.x_target       = wp_tab[cur_wp].x;
        res.y_target       = wp_tab[cur_wp].y;
        res.heading_target = held_hdg[15:0];
        res.waypoint_index = cur_wp[IDX_W-1:0];
        res.advanced       = adv;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    function automatic int wait_draw();
        return quiet ? 0 : int'($urandom_range(0, 15));
    endfunction

    // value within lim-1 of c, clamped to the 16-bit range
    function automatic int near(input int c, input int lim);
        if (lim <= 0) begin
            return c;
        end
        return clamp16(c + int'($urandom_range(0, 2 * lim - 2)) - (lim - 1));
    endfunction

    function automatic t_result mk_res(input int x, input int y, input int h,
                                       input int idx, input bit adv);
        t_result r;
        r.x_target       = x[15:0];
        r.y_target       = y[15:0];
        r.heading_target = h[15:0];
        r.waypoint_index = idx[IDX_W-1:0];
        r.advanced       = adv;
        return r;
    endfunction

    function automatic t_cfg mk_cfg(input int pl, input int thr, input int sd,
                                    input int ld, input int tol, input int snap,
                                    input int step);
        t_cfg c;
        c.path_length       = pl[3:0];
        c.dist_threshold    = thr[15:0];
        c.short_dwell       = sd[15:0];
        c.long_dwell        = ld[15:0];
        c.heading_tolerance = tol[11:0];
        c.snap_band         = snap[11:0];
        c.slew_step         = step[7:0];
        return c;
    endfunction

    function automatic void add_cfg(input t_cfg_index sel, input int val);
        t_dir_row r;
        r = '{kind: ROW_CFG, reg_sel: CFG_PATH_LENGTH, default: '0};
        r.kind    = ROW_CFG;
        r.reg_sel = sel;
        r.reg_val = val[15:0];
        dir_rows.push_back(r);
    endfunction

    function automatic void add_wr(input int slot, input int ex, input int ey,
                                   input int eh, input bit has_exp,
                                   input t_result want);
        t_dir_row r;
        r = '{kind: ROW_ITEM, reg_sel: CFG_PATH_LENGTH, default: '0};
        r.kind             = ROW_ITEM;
        r.item.opcode      = OP_WRITE;
        r.item.entry_index = slot[IDX_W-1:0];
        r.item.entry.x     = ex[15:0];
        r.item.entry.y     = ey[15:0];
        r.item.entry.h     = eh[15:0];
        r.has_exp          = has_exp;
        r.exp_res          = want;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_meas(input int px, input int py, input int ph);
        t_dir_row r;
        r = '{kind: ROW_ITEM, reg_sel: CFG_PATH_LENGTH, default: '0};
        r.kind         = ROW_ITEM;
        r.item.opcode  = OP_MEASURE;
        r.item.x_pos   = px[15:0];
        r.item.y_pos   = py[15:0];
        r.item.heading = ph[15:0];
        dir_rows.push_back(r);
    endfunction

    // Random item shaped around the current waypoint: mostly settled heading
    // and in-range position, plus heading-off, out-of-range, table writes
    // (a third of those past slot 0 copying the predecessor) and raw noise.
    function automatic t_item rand_item();
        t_item       it;
        t_waypoint   w;
        int          pick;
        int          tol;
        int          thr;
        int          sgn;
        int unsigned slot;
        it.opcode      = OP_MEASURE;
        it.x_pos       = rnd16();
        it.y_pos       = rnd16();
        it.heading     = rnd16();
        it.entry_index = t_idx'($urandom);
        it.entry.x     = rnd16();
        it.entry.y     = rnd16();
        it.entry.h     = rnd16();
        w    = wp_tab[cur_wp];
        tol  = cfg_m.heading_tolerance;
        thr  = cfg_m.dist_threshold;
        sgn  = $urandom_range(0, 1) ? 1 : -1;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            it.opcode      = OP_WRITE;
            slot           = $urandom_range(0, MAX_WAYPOINTS - 1);
            it.entry_index = t_idx'(slot);
            if (slot > 0 && $urandom_range(0, 2) == 0) begin
                it.entry = wp_tab[slot - 1];
            end
        end else if (pick >= 20) begin
            it.heading = 16'(near($signed(w.h), tol));
            it.x_pos   = 16'(near($signed(w.x), thr));
            it.y_pos   = 16'(near($signed(w.y), thr));
            if (pick < 32) begin
                it.heading = 16'(clamp16($signed(w.h)
                                 + sgn * (tol + int'($urandom_range(0, 600)))));
            end else if (pick < 42) begin
                it.y_pos = 16'(clamp16($signed(w.y)
                               + sgn * (thr + int'($urandom_range(0, 300)))));
            end
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // channel tasks
    // ------------------------------------------------------------------
    task automatic flag(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    // one register write; the caller drops the write enable afterwards
    task automatic write_reg(input t_cfg_index sel, input logic [15:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (sel)
            CFG_PATH_LENGTH:       cfg_m.path_length       = val[3:0];
            CFG_DIST_THRESHOLD:    cfg_m.dist_threshold    = val;
            CFG_SHORT_DWELL:       cfg_m.short_dwell       = val;
            CFG_LONG_DWELL:        cfg_m.long_dwell        = val;
            CFG_HEADING_TOLERANCE: cfg_m.heading_tolerance = val[11:0];
            CFG_SNAP_BAND:         cfg_m.snap_band         = val[11:0];
            CFG_SLEW_STEP:         cfg_m.slew_step         = val[7:0];
            default: ;
        endcase
    endtask

    // Stop sending, let every predicted result come back, then give the
    // result path time to empty before anything is reconfigured.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (guidance_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_cfg(input t_cfg c);
        drain();
        write_reg(CFG_PATH_LENGTH,       16'(c.path_length));
        write_reg(CFG_DIST_THRESHOLD,    c.dist_threshold);
        write_reg(CFG_SHORT_DWELL,       c.short_dwell);
        write_reg(CFG_LONG_DWELL,        c.long_dwell);
        write_reg(CFG_HEADING_TOLERANCE, 16'(c.heading_tolerance));
        write_reg(CFG_SNAP_BAND,         16'(c.snap_band));
        write_reg(CFG_SLEW_STEP,         16'(c.slew_step));
        i_cfg_wr_en <= 1'b0;
    endtask

    // Present one item after a random gap and hold it until the transfer.
    // Returns at the accepting edge with nothing scheduled, so the next call
    // either keeps valid high with a new payload or drops it.
    task automatic send_item(input t_item it, input bit has_exp, input t_result want);
        t_result pred;
        int      gap;
        gap = wait_draw();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= it.opcode;
        i_x_pos         <= it.x_pos;
        i_y_pos         <= it.y_pos;
        i_heading       <= it.heading;
        i_entry_index   <= it.entry_index;
        i_entry_x       <= it.entry.x;
        i_entry_y       <= it.entry.y;
        i_entry_heading <= it.entry.h;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        pred = guide_step(it);
        guidance_q.push_back(has_exp ? want : pred);
    endtask

    // ------------------------------------------------------------------
    // receiver: random stall before each result, then take it
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold;
        wait (i_rst_n);
        forever begin
            hold = wait_draw();
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) begin
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // result check: every output transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (guidance_q.size() == 0) begin
                flag("result transfer with no prediction waiting");
            end else begin
                want = guidance_q.pop_front();
                if (o_x_target !== want.x_target) begin
                    flag($sformatf("x_target %0d, expected %0d",
                                   o_x_target, $signed(want.x_target)));
                end
                if (o_y_target !== want.y_target) begin
                    flag($sformatf("y_target %0d, expected %0d",
                                   o_y_target, $signed(want.y_target)));
                end
                if (o_heading_target !== want.heading_target) begin
                    flag($sformatf("heading_target %0d, expected %0d",
                                   o_heading_target, $signed(want.heading_target)));
                end
                if (o_waypoint_index !== want.waypoint_index) begin
                    flag($sformatf("waypoint_index %0d, expected %0d",
                                   o_waypoint_index, want.waypoint_index));
                end
                if (o_advanced !== want.advanced) begin
                    flag($sformatf("advanced %0b, expected %0b",
                                   o_advanced, want.advanced));
                end
            end
        end
    end

    // watchdog: a long run of cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_cfg  phase_cfg [N_PHASES];
        int    phase_len [N_PHASES];
        t_item it;
        int    n;

        cfg_m = mk_cfg(RST_PATH_LENGTH, RST_DIST_THRESHOLD, RST_SHORT_DWELL,
                       RST_LONG_DWELL, RST_HEADING_TOLERANCE, RST_SNAP_BAND,
                       RST_SLEW_STEP);

        // Directed table. Dwells shortened so each step is visible at once.
        // Slot 0 goes first so that no result ever shows an unwritten slot;
        // every slot is loaded before the first measurement.
        add_cfg(CFG_SHORT_DWELL, 1);
        add_cfg(CFG_LONG_DWELL, 2);
        add_wr(0, 100, 200, 0, 1'b1, mk_res(100, 200, 0, 0, 1'b0));
        // a write changes the table only: result still shows slot 0
        add_wr(1, 32767, -32768, 900, 1'b1, mk_res(100, 200, 0, 0, 1'b0));
        add_wr(2, -32768, 32767, -32768, 1'b0, '0);
        add_wr(3, -32768, 32767, -32768, 1'b0, '0);   // repeat of slot 2
        add_wr(4, 0, 0, 32767, 1'b0, '0);
        add_wr(5, 5, 5, 5, 1'b0, '0);
        add_wr(6, -1, -1, -1, 1'b0, '0);
        add_wr(7, 0, 0, 0, 1'b0, '0);
        add_meas(149, 151, 49);                // just inside heading and range
        add_meas(0, 0, 0);                     // heading off: slew
        add_meas(32767, -32768, 950);          // gap equal to tolerance: slew
        add_meas(32767, -32768, 900);          // on the waypoint: advance
        add_meas(-32718, 32767, -32768);       // distance equal to threshold: miss
        add_meas(-32768, 32767, -32768);       // advance onto repeated waypoint
        add_meas(32767, 32767, -32768);        // long dwell, position ignored
        add_meas(0, 0, 0);                     // heading off keeps the dwell count
        add_meas(-32768, -32768, -32768);      // long dwell complete
        add_meas(0, 0, 32767);
        add_meas(5, 5, 5);                     // index wraps at path length
        add_meas(100, 200, -32768);            // setpoint inside snap band: snap

        // random phases: low and high values of every register, out-of-range path length
        phase_cfg[0] = mk_cfg(8, 65535, 1, 1, 3600, 0, 255);
        phase_len[0] = 120;
        phase_cfg[1] = mk_cfg(1, 0, 65535, 65535, 0, 3600, 0);
        phase_len[1] = 40;
        phase_cfg[2] = mk_cfg(3, 200, 3, 5, 100, 20, 7);
        phase_len[2] = 120;
        phase_cfg[3] = mk_cfg(0, 1000, 2, 3, 400, 50, 16);
        phase_len[3] = 100;
        phase_cfg[4] = mk_cfg(15, 20, 4, 2, 30, 10, 1);
        phase_len[4] = 100;
        phase_cfg[5] = mk_cfg(6, 50, 5, 12, 50, 30, 2);
        phase_len[5] = 80;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain();
                write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
                i_cfg_wr_en <= 1'b0;
            end else begin
                send_item(dir_rows[i].item, dir_rows[i].has_exp, dir_rows[i].exp_res);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            apply_cfg(phase_cfg[p]);
            for (int k = 0; k < phase_len[p]; k++) begin
                if ($urandom_range(0, 31) == 0) begin
                    quiet = !quiet;
                end
                send_item(rand_item(), 1'b0, '0);
            end
        end

        // Setpoint saturation: zero tolerance keeps every measurement in the
        // slew branch, full step and no snap band drive it into the top rail.
        apply_cfg(mk_cfg(8, 50, 3, 3, 0, 0, 255));
        it             = rand_item();
        it.opcode      = OP_WRITE;
        it.entry_index = cur_wp[IDX_W-1:0];
        it.entry.h     = 16'sh7FFF;
        send_item(it, 1'b0, '0);
        n = 0;
        while ((held_hdg != 32767 && n < 300) || n < 8) begin
            if ($urandom_range(0, 31) == 0) begin
                quiet = !quiet;
            end
            it        = rand_item();
            it.opcode = OP_MEASURE;
            send_item(it, 1'b0, '0);
            n++;
        end

        drain();
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- waypoint_sequencer_with_dwell.f -----
sv/wsd_pkg.sv
sv/wsd_cfg.sv
sv/wsd_step.sv
sv/wsd_skid.sv
sv/waypoint_sequencer_with_dwell.sv
test/waypoint_sequencer_with_dwell_tb.sv
